[hw/rtl/bhtp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bhtp_pkg
// shared types, codes and the letter-pair fold for the hash table probe
// ----------------------------------------------------------------------------
package bhtp_pkg;

    localparam int unsigned SUM_W = 17;
    localparam logic [SUM_W-1:0] FOLD_PRIME = 17'd36373;
    localparam logic [SUM_W-1:0] PAIR_WEIGHT = 17'd100;
    localparam logic [7:0] PAD_LETTER = 8'h5A;   // 'Z'
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    // per-key control carried from front to back
    typedef struct packed {
        logic             req;
        logic             ovf;
        logic [SUM_W-1:0] sum;
    } t_job_ctl;

    // result beat, status in the lowest bits
    typedef struct packed {
        logic [1:0] slot;
        logic [7:0] bucket;
        logic [9:0] probes;
        t_status    status;
    } t_result;

    function automatic logic [SUM_W-1:0] fold_add(input logic [SUM_W-1:0] sum,
                                                   input logic [7:0] first,
                                                   input logic [7:0] second);
        logic [SUM_W-1:0] t;
        t = sum + SUM_W'(first) * PAIR_WEIGHT + SUM_W'(second);
        return (t >= FOLD_PRIME) ? t - FOLD_PRIME : t;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/bhtp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bhtp_front
// collects key bytes, folds letter pairs, hands finished keys to the queue
// ----------------------------------------------------------------------------
module bhtp_front #(
    parameter int KEY_CHARS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_beat,
    input  wire                          i_req,
    input  wire  [7:0]                   i_char,
    input  wire                          i_last,
    output logic                         o_push,
    output bhtp_pkg::t_job_ctl           o_ctl,
    output logic [$clog2(KEY_CHARS+1)-1:0] o_len,
    output logic [KEY_CHARS*8-1:0]       o_chars
);
    import bhtp_pkg::*;

    localparam int LW = $clog2(KEY_CHARS + 1);
    localparam int IW = $clog2(KEY_CHARS);

    logic [KEY_CHARS*8-1:0] r_chars, n_chars;
    logic [LW-1:0]          r_len, n_len;
    logic                   r_ovf, n_ovf;
    logic                   r_par, n_par;
    logic [7:0]             r_pend, n_pend;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [7:0]             up;
    logic                   is_letter;
    logic [SUM_W-1:0]       fin_sum;

    always_comb begin
        n_chars = r_chars;
        n_len   = r_len;
        n_ovf   = r_ovf;
        if (r_len < LW'(KEY_CHARS)) begin
            n_chars[{r_len[IW-1:0], 3'b000} +: 8] = i_char;
            n_len = r_len + LW'(1);
        end else begin
            n_ovf = 1'b1;
        end
        up = (i_char >= 8'h61 && i_char <= 8'h7A) ? i_char - CASE_OFFSET : i_char;
        is_letter = (up >= 8'h41 && up <= 8'h5A);
        n_par  = r_par;
        n_pend = r_pend;
        n_sum  = r_sum;
        if (is_letter) begin
            if (r_par) begin
                n_sum = fold_add(r_sum, r_pend, up);
                n_par = 1'b0;
            end else begin
                n_pend = up;
                n_par  = 1'b1;
            end
        end
        // odd letter count pairs with the pad letter
        fin_sum = n_par ? fold_add(n_sum, n_pend, PAD_LETTER) : n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_ovf  <= 1'b0;
            r_par  <= 1'b0;
            r_pend <= '0;
            r_sum  <= '0;
        end else if (i_beat) begin
            if (i_last) begin
                r_len  <= '0;
                r_ovf  <= 1'b0;
                r_par  <= 1'b0;
                r_pend <= '0;
                r_sum  <= '0;
            end else begin
                r_len  <= n_len;
                r_ovf  <= n_ovf;
                r_par  <= n_par;
                r_pend <= n_pend;
                r_sum  <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_beat) begin
            r_chars <= n_chars;
        end
    end

    assign o_push     = i_beat && i_last;
    assign o_ctl.req  = i_req;
    assign o_ctl.ovf  = n_ovf;
    assign o_ctl.sum  = fin_sum;
    assign o_len      = n_len;
    assign o_chars    = n_chars;

    a_key_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beat && i_last) |=> (r_len == '0 && !r_par && !r_ovf))
        else $error("key state not cleared after last beat");

endmodule
`default_nettype wire

[hw/rtl/bhtp_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bhtp_queue
// two-entry queue of finished keys between front and back
// ----------------------------------------------------------------------------
module bhtp_queue #(
    parameter int WIDTH = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rp];

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push |-> !o_full) and (i_pop |-> !o_empty))
        else $error("queue overrun or underrun");

endmodule
`default_nettype wire

[hw/rtl/bhtp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bhtp_back
// home bucket reduction, probe walk over the entry tables, result register
// ----------------------------------------------------------------------------
module bhtp_back #(
    parameter int NUM_BUCKETS      = 256,
    parameter int SLOTS_PER_BUCKET = 3,
    parameter int KEY_CHARS        = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    output logic                           o_clearing,
    input  wire                            i_empty,
    output logic                           o_pop,
    input  bhtp_pkg::t_job_ctl             i_ctl,
    input  wire  [$clog2(KEY_CHARS+1)-1:0] i_len,
    input  wire  [KEY_CHARS*8-1:0]         i_chars,
    output logic                           o_valid,
    input  wire                            i_ready,
    output bhtp_pkg::t_result              o_result
);
    import bhtp_pkg::*;

    localparam int TOTAL  = NUM_BUCKETS * SLOTS_PER_BUCKET;
    localparam int STRIDE = SLOTS_PER_BUCKET * KEY_CHARS;
    localparam int EW     = $clog2(TOTAL);
    localparam int BW     = $clog2(NUM_BUCKETS);
    localparam int SLW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int LW     = $clog2(KEY_CHARS + 1);
    localparam int IW     = $clog2(KEY_CHARS);
    localparam int CAW    = $clog2(TOTAL * KEY_CHARS);
    localparam int PW     = $clog2(TOTAL + 1);
    localparam int RW     = SUM_W + BW;
    localparam int KW     = $clog2(SUM_W);
    // folded sum stays below 36373, so 16 bits carry it
    localparam int DW     = 16;
    localparam int SH     = DW + $clog2(NUM_BUCKETS);
    localparam int MW     = DW + 1;
    // reciprocal of the bucket count, rounded up, exact for 16-bit sums
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_REDUCE = 10'b0000000100,
        S_HOME   = 10'b0000001000,
        S_RD     = 10'b0000010000,
        S_CHK    = 10'b0000100000,
        S_CRD    = 10'b0001000000,
        S_CCHK   = 10'b0010000000,
        S_WR     = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state                 r_state;
    logic [EW-1:0]          r_clr;
    logic [RW-1:0]          r_rem, r_div;
    logic [KW-1:0]          r_k;
    logic [EW-1:0]          r_e;
    logic [CAW-1:0]         r_base;
    logic [BW-1:0]          r_bkt;
    logic [SLW-1:0]         r_slot;
    logic [PW-1:0]          r_probes;
    logic [IW-1:0]          r_j;
    logic                   r_req;
    logic [LW-1:0]          r_len;
    logic [KEY_CHARS*8-1:0] r_chars;
    t_result                r_pend, r_res;
    logic                   r_out_valid;

    // entry tables: valid bit over stored length, and key bytes
    logic [LW:0]            r_meta [TOTAL];
    logic [7:0]             r_text [TOTAL*KEY_CHARS];
    logic [LW:0]            r_meta_q;
    logic [7:0]             r_text_q;

    logic                   meta_we;
    logic [EW-1:0]          meta_wa;
    logic [LW:0]            meta_wd;
    logic [CAW-1:0]         text_a;
    logic [7:0]             key_byte;
    logic                   last_byte;
    logic                   walk_end;
    logic                   out_free;
    logic [DW+MW-1:0]       quot_full;

    function automatic t_result make_result(input t_status st, input logic [PW-1:0] pr,
                                            input logic [BW-1:0] bk,
                                            input logic [SLW-1:0] sl);
        t_result r;
        r.status = st;
        r.probes = 10'(pr);
        r.bucket = 8'(bk);
        r.slot   = 2'(sl);
        return r;
    endfunction

    assign text_a    = r_base + CAW'(r_j);
    assign key_byte  = r_chars[{r_j, 3'b000} +: 8];
    assign last_byte = (r_j == IW'(r_len - LW'(1)));
    assign walk_end  = (r_probes == PW'(TOTAL));
    assign out_free  = !r_out_valid || i_ready;
    assign quot_full = (DW+MW)'(r_rem[DW-1:0]) * (DW+MW)'(RECIP);

    always_comb begin
        meta_we = 1'b0;
        meta_wa = r_e;
        meta_wd = {1'b1, r_len};
        if (r_state == S_CLEAR) begin
            meta_we = 1'b1;
            meta_wa = r_clr;
            meta_wd = '0;
        end else if (r_state == S_CHK && !r_meta_q[LW] && r_req == REQ_INSERT) begin
            meta_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meta_q <= r_meta[r_e];
        if (meta_we) begin
            r_meta[meta_wa] <= meta_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_text_q <= r_text[text_a];
        if (r_state == S_WR) begin
            r_text[text_a] <= key_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + EW'(1);
                    if (r_clr == EW'(TOTAL - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_req   <= i_ctl.req;
                        r_len   <= i_len;
                        r_chars <= i_chars;
                        r_rem   <= RW'(i_ctl.sum);
                        r_div   <= '0;
                        r_k     <= KW'(1);
                        if (i_ctl.ovf) begin
                            r_pend  <= make_result(ST_TOO_LONG, '0, '0, '0);
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_REDUCE;
                        end
                    end
                end
                S_REDUCE: begin
                    // quotient by reciprocal multiply, then remainder
                    if (r_k != '0) begin
                        r_div <= RW'(quot_full >> SH);
                        r_k   <= '0;
                    end else begin
                        r_rem   <= r_rem - r_div * RW'(NUM_BUCKETS);
                        r_state <= S_HOME;
                    end
                end
                S_HOME: begin
                    r_e      <= EW'(r_rem[BW-1:0]) * EW'(SLOTS_PER_BUCKET);
                    r_base   <= CAW'(r_rem[BW-1:0]) * CAW'(STRIDE);
                    r_bkt    <= r_rem[BW-1:0];
                    r_slot   <= '0;
                    r_probes <= PW'(1);
                    r_state  <= S_RD;
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK, S_CCHK: begin
                    if (r_state == S_CHK && !r_meta_q[LW]) begin
                        if (r_req == REQ_INSERT) begin
                            r_j     <= '0;
                            r_state <= S_WR;
                        end else begin
                            r_pend  <= make_result(ST_NOT_FOUND, r_probes, '0, '0);
                            r_state <= S_DONE;
                        end
                    end else if (r_state == S_CHK && r_req == REQ_SEARCH
                                 && r_meta_q[LW-1:0] == r_len) begin
                        r_j     <= '0;
                        r_state <= S_CRD;
                    end else if (r_state == S_CCHK && r_text_q == key_byte) begin
                        if (last_byte) begin
                            r_pend  <= make_result(ST_FOUND, r_probes, r_bkt, r_slot);
                            r_state <= S_DONE;
                        end else begin
                            r_j     <= r_j + IW'(1);
                            r_state <= S_CRD;
                        end
                    end else if (walk_end) begin
                        r_pend  <= make_result((r_req == REQ_INSERT) ? ST_FULL : ST_NOT_FOUND,
                                               r_probes, '0, '0);
                        r_state <= S_DONE;
                    end else begin
                        // step to the next entry with wrap
                        r_probes <= r_probes + PW'(1);
                        r_state  <= S_RD;
                        if (r_e == EW'(TOTAL - 1)) begin
                            r_e    <= '0;
                            r_base <= '0;
                            r_bkt  <= '0;
                            r_slot <= '0;
                        end else begin
                            r_e    <= r_e + EW'(1);
                            r_base <= r_base + CAW'(KEY_CHARS);
                            if (r_slot == SLW'(SLOTS_PER_BUCKET - 1)) begin
                                r_slot <= '0;
                                r_bkt  <= r_bkt + BW'(1);
                            end else begin
                                r_slot <= r_slot + SLW'(1);
                            end
                        end
                    end
                end
                S_CRD: begin
                    r_state <= S_CCHK;
                end
                S_WR: begin
                    if (last_byte) begin
                        r_pend  <= make_result(ST_INSERTED, r_probes, r_bkt, r_slot);
                        r_state <= S_DONE;
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_res   <= r_pend;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_clearing = (r_state == S_CLEAR);
    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign o_valid    = r_out_valid;
    assign o_result   = r_res;

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside done state");

    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_probes != '0 && r_probes <= PW'(TOTAL)))
        else $error("probe count out of range");

endmodule
`default_nettype wire

[hw/rtl/bucketed_hash_table_probe.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bucketed_hash_table_probe
// bucketed hash table with linear probing, keys streamed one byte per beat
// ----------------------------------------------------------------------------
//  channel   dir  bits                                        beat
//  s_axis    in   tdata[7:0] char, tuser req, tlast last      one key character
//  m_axis    out  tdata[23:0] status/probes/bucket/slot       one result per key
//
//  the front takes one character beat per cycle while s_axis is ready; a key's
//  last beat queues it; the back takes a queued key, reduces the sum to the home
//  bucket and sets up the walk, then reads and checks each entry probed, reads
//  and compares each byte on a search length match, stores each byte on insert,
//  and hands off the result
//  after reset the NUM_BUCKETS * SLOTS_PER_BUCKET entry valid bits (768 by
//  default) are cleared one per cycle, with s_axis not ready meanwhile
//  up to two finished keys wait between front and back; a stalled result
//  holds the back but the front keeps taking characters until the queue fills
// ----------------------------------------------------------------------------
module bucketed_hash_table_probe #(
    parameter int NUM_BUCKETS      = 256,
    parameter int SLOTS_PER_BUCKET = 3,
    parameter int KEY_CHARS        = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  wire         i_s_axis_tuser,   // [0] req_type
    input  wire         i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata    // [2:0] status, [12:3] probes,
                                          // [20:13] bucket_index, [22:21] slot_index
);
    import bhtp_pkg::*;

    localparam int LW = $clog2(KEY_CHARS + 1);
    localparam int QW = KEY_CHARS * 8 + LW + $bits(t_job_ctl);

    logic                   beat;
    logic                   push, pop, full, empty, clearing;
    t_job_ctl               f_ctl, b_ctl;
    logic [LW-1:0]          f_len, b_len;
    logic [KEY_CHARS*8-1:0] f_chars, b_chars;
    logic [QW-1:0]          q_in, q_out;
    t_result                result;

    // hold off characters while clearing or when no queue room for a key
    assign o_s_axis_tready = !full && !clearing;
    assign beat            = i_s_axis_tvalid && o_s_axis_tready;

    bhtp_front #(
        .KEY_CHARS (KEY_CHARS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (beat),
        .i_req   (i_s_axis_tuser),
        .i_char  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_push  (push),
        .o_ctl   (f_ctl),
        .o_len   (f_len),
        .o_chars (f_chars)
    );

    assign q_in = {f_chars, f_len, f_ctl};

    bhtp_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_out)
    );

    assign {b_chars, b_len, b_ctl} = q_out;

    bhtp_back #(
        .NUM_BUCKETS      (NUM_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
        .KEY_CHARS        (KEY_CHARS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_clearing (clearing),
        .i_empty    (empty),
        .o_pop      (pop),
        .i_ctl      (b_ctl),
        .i_len      (b_len),
        .i_chars    (b_chars),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_result   (result)
    );

    assign o_m_axis_tdata = {1'b0, result};

    a_quiet_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (!o_s_axis_tready && !o_m_axis_tvalid))
        else $error("traffic during table clear");

endmodule
`default_nettype wire
